// ----- hdl/true_color_pixel_to_rgb888_assert.svh -----
// assertion macros shared by the checker
`ifndef TRUE_COLOR_PIXEL_TO_RGB888_ASSERT_SVH
`define TRUE_COLOR_PIXEL_TO_RGB888_ASSERT_SVH

// same-cycle implication, off while in reset
`define TCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define TCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/tcp_rgb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcp_rgb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PixW     = 32;
  localparam int unsigned BppW     = 3;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned MaxW     = 16;
  localparam int unsigned NumW     = 24;
  localparam int unsigned QuoW     = 8;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned NumChan  = 3;

  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBpp        = 3'd0,
    CfgBigEndian  = 3'd1,
    CfgRedShift   = 3'd2,
    CfgGreenShift = 3'd3,
    CfgBlueShift  = 3'd4,
    CfgRedMax     = 3'd5,
    CfgGreenMax   = 3'd6,
    CfgBlueMax    = 3'd7
  } cfg_idx_e;

  typedef logic [MaxW-1:0] chan_val_t;
  typedef logic [NumW-1:0] num_t;
  typedef logic [QuoW-1:0] quo_t;

endpackage

`default_nettype wire

// ----- hdl/true_color_pixel_to_rgb888.sv -----
`timescale 1ns / 1ps
`default_nettype none

// True-color pixel to RGB888 converter. Takes one pixel beat per clock unless
// an output stall backs the pipeline up, and gives one red/green/blue beat per
// pixel, in order. Most of the pipeline depth is the scaling divider: every
// channel runs an eight-stage restoring divider that settles one quotient bit
// per stage, after three stages for byte assembly, shift and mask, and the
// numerator (raw*255 + max/2). Valid bits travel with the data; a stall at the
// output holds full stages in place while empty stages keep filling, so nothing
// is lost or repeated. Configuration is written through the cfg_* port and
// must only change while the pipeline is empty; a zero channel max gives zero
// on that channel.
module true_color_pixel_to_rgb888 (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tcp_rgb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [tcp_rgb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [tcp_rgb_pkg::PixW-1:0]       raw_pixel_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [7:0]                              red_o,
  output logic [7:0]                              green_o,
  output logic [7:0]                              blue_o
);

  localparam int unsigned NumChan = tcp_rgb_pkg::NumChan;
  localparam int unsigned DivSteps = tcp_rgb_pkg::DivSteps;
  localparam int unsigned NumW = tcp_rgb_pkg::NumW;
  localparam int unsigned QuoW = tcp_rgb_pkg::QuoW;
  localparam int unsigned DivStg0 = 3;
  localparam int unsigned NumStg = DivStg0 + DivSteps;

  logic [tcp_rgb_pkg::BppW-1:0]   bpp_q;
  logic                           big_endian_q;
  logic [tcp_rgb_pkg::ShiftW-1:0] shift_q [NumChan];
  tcp_rgb_pkg::chan_val_t         max_q [NumChan];

  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   rdy;

  logic [tcp_rgb_pkg::BppW-1:0] nbytes;
  logic [tcp_rgb_pkg::PixW-1:0] pix_d, pix_q;
  tcp_rgb_pkg::chan_val_t       raw_d [NumChan];
  tcp_rgb_pkg::chan_val_t       raw_q [NumChan];
  tcp_rgb_pkg::num_t            num_d [NumChan];
  tcp_rgb_pkg::num_t            rem_q [DivSteps][NumChan];
  tcp_rgb_pkg::quo_t            quo_q [DivSteps][NumChan];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= 3'd4;
      big_endian_q <= 1'b0;
      shift_q[tcp_rgb_pkg::ChRed] <= 5'd16;
      shift_q[tcp_rgb_pkg::ChGreen] <= 5'd8;
      shift_q[tcp_rgb_pkg::ChBlue] <= 5'd0;
      max_q[tcp_rgb_pkg::ChRed] <= 16'd255;
      max_q[tcp_rgb_pkg::ChGreen] <= 16'd255;
      max_q[tcp_rgb_pkg::ChBlue] <= 16'd255;
    end else if (cfg_we_i) begin
      unique case (tcp_rgb_pkg::cfg_idx_e'(cfg_idx_i))
        tcp_rgb_pkg::CfgBpp: begin
          bpp_q <= cfg_data_i[tcp_rgb_pkg::BppW-1:0];
        end
        tcp_rgb_pkg::CfgBigEndian: begin
          big_endian_q <= cfg_data_i[0];
        end
        tcp_rgb_pkg::CfgRedShift: begin
          shift_q[tcp_rgb_pkg::ChRed] <= cfg_data_i[tcp_rgb_pkg::ShiftW-1:0];
        end
        tcp_rgb_pkg::CfgGreenShift: begin
          shift_q[tcp_rgb_pkg::ChGreen] <= cfg_data_i[tcp_rgb_pkg::ShiftW-1:0];
        end
        tcp_rgb_pkg::CfgBlueShift: begin
          shift_q[tcp_rgb_pkg::ChBlue] <= cfg_data_i[tcp_rgb_pkg::ShiftW-1:0];
        end
        tcp_rgb_pkg::CfgRedMax: begin
          max_q[tcp_rgb_pkg::ChRed] <= cfg_data_i;
        end
        tcp_rgb_pkg::CfgGreenMax: begin
          max_q[tcp_rgb_pkg::ChGreen] <= cfg_data_i;
        end
        tcp_rgb_pkg::CfgBlueMax: begin
          max_q[tcp_rgb_pkg::ChBlue] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // per-stage ready chain, a stage moves when empty or when the next one moves
  always_comb begin
    rdy[NumStg] = out_ready_i;
    for (int i = NumStg - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  assign in_ready_o = rdy[0];
  assign out_valid_o = v_q[NumStg-1];

  // byte assembly
  assign nbytes = (bpp_q > 3'd4) ? 3'd4 : bpp_q;

  always_comb begin
    pix_d = '0;
    if (big_endian_q) begin
      case (nbytes)
        3'd1: pix_d = {24'd0, raw_pixel_i[7:0]};
        3'd2: pix_d = {16'd0, raw_pixel_i[7:0], raw_pixel_i[15:8]};
        3'd3: pix_d = {8'd0, raw_pixel_i[7:0], raw_pixel_i[15:8], raw_pixel_i[23:16]};
        3'd4: pix_d = {raw_pixel_i[7:0], raw_pixel_i[15:8], raw_pixel_i[23:16],
                       raw_pixel_i[31:24]};
        default: pix_d = '0;
      endcase
    end else begin
      case (nbytes)
        3'd1: pix_d = {24'd0, raw_pixel_i[7:0]};
        3'd2: pix_d = {16'd0, raw_pixel_i[15:0]};
        3'd3: pix_d = {8'd0, raw_pixel_i[23:0]};
        3'd4: pix_d = raw_pixel_i;
        default: pix_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pix_q <= pix_d;
    end
  end

  // shift, mask, then numerator raw*255 + max/2
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      raw_d[c] = tcp_rgb_pkg::MaxW'(pix_q >> shift_q[c]) & max_q[c];
      num_d[c] = (NumW'(raw_q[c]) << QuoW) - NumW'(raw_q[c]) + NumW'(max_q[c] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumChan; c++) begin
      if (rdy[1]) begin
        raw_q[c] <= raw_d[c];
      end
      if (rdy[2]) begin
        rem_q[0][c] <= num_d[c];
      end
    end
  end

  // restoring divide by max, one quotient bit per stage, msb first
  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    for (genvar c = 0; c < NumChan; c++) begin : g_chan
      tcp_rgb_pkg::num_t dsr;
      tcp_rgb_pkg::quo_t qprev;
      logic              ge;

      assign dsr = NumW'(max_q[c]) << (DivSteps - 1 - s);
      assign ge = rem_q[s][c] >= dsr;

      if (s == 0) begin : g_first
        assign qprev = '0;
      end else begin : g_next
        assign qprev = quo_q[s-1][c];
      end

      if (s < DivSteps - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (rdy[DivStg0+s]) begin
            rem_q[s+1][c] <= ge ? rem_q[s][c] - dsr : rem_q[s][c];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (rdy[DivStg0+s]) begin
          quo_q[s][c] <= {qprev[QuoW-2:0], ge};
        end
      end
    end
  end

  assign red_o = (max_q[tcp_rgb_pkg::ChRed] == '0) ? '0 :
                 quo_q[DivSteps-1][tcp_rgb_pkg::ChRed];
  assign green_o = (max_q[tcp_rgb_pkg::ChGreen] == '0) ? '0 :
                   quo_q[DivSteps-1][tcp_rgb_pkg::ChGreen];
  assign blue_o = (max_q[tcp_rgb_pkg::ChBlue] == '0) ? '0 :
                  quo_q[DivSteps-1][tcp_rgb_pkg::ChBlue];

endmodule

`default_nettype wire

// ----- hdl/tcp_rgb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "true_color_pixel_to_rgb888_assert.svh"

module tcp_rgb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_i,
  input wire logic [7:0] green_i,
  input wire logic [7:0] blue_i
);

  logic out_stall;
  logic in_busy;

  assign out_stall = out_valid_i && !out_ready_i;
  assign in_busy = in_valid_i && !in_ready_i;

  // a held result keeps its beat
  `TCP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
                  out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i))

  // with the output stage empty the whole pipeline can move
  `TCP_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // a taken output frees a slot all the way back to the input
  `TCP_ASSERT_IMP(a_ready_when_drained, clk_i, rst_ni, out_ready_i, in_ready_i)

  // the input only backs up while a result is held at the output
  `TCP_ASSERT_IMP(a_backpressure_cause, clk_i, rst_ni, in_busy, out_stall)

endmodule

bind true_color_pixel_to_rgb888 tcp_rgb_checker u_tcp_rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_i       (red_o),
  .green_i     (green_o),
  .blue_i      (blue_o)
);

`default_nettype wire
